// ----- sv/ftbp_pkg.sv -----
package ftbp_pkg;

  // Hard ceiling on the bytes of one packed stream.
  localparam int MAX_OUT_BYTES = 4096;

  // Widest element slice that can be taken from one input item.
  localparam int ELEM_W = 16;

  // Up to two full bytes plus one flushed partial byte per item.
  localparam int RES_MAX = 3;

  // Configuration register indexes.
  localparam logic CFG_ELEMENT_BITS = 1'b0;
  localparam logic CFG_MAX_BYTES    = 1'b1;

  // Packer state carried from one item to the next.
  typedef struct packed {
    logic [6:0]  lo_bits;
    logic [2:0]  lo_cnt;
    logic [12:0] emitted;
  } pack_state_t;

  // Bytes produced by one item, plus the state it leaves behind.
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [RES_MAX-1:0]      lasts;
    logic [1:0]              count;
    pack_state_t             state;
  } pack_res_t;

endpackage

// ----- sv/ftbp_if.sv -----
// Input channel: one element per item.
interface ftbp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] element;
  logic        last_element;

  modport source (output valid, output element, output last_element, input ready);
  modport sink   (input valid, input element, input last_element, output ready);
endinterface

// Result channel: one packed byte per item.
interface ftbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_byte;

  modport source (output valid, output packed_byte, output last_byte, input ready);
  modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

// ----- sv/ftbp_core.sv -----
module ftbp_core (
  input  logic [4:0]           element_bits,
  input  logic [12:0]          max_bytes,
  input  logic [15:0]          element,
  input  logic                 last_element,
  input  ftbp_pkg::pack_state_t state,
  output ftbp_pkg::pack_res_t   res
);

  logic [4:0]  n;
  logic [12:0] lim;
  logic [15:0] mask;
  logic [22:0] acc;
  logic [4:0]  cnt;
  logic [1:0]  full;
  logic        at_lim;
  logic [12:0] room;
  logic [1:0]  emit;
  logic [4:0]  sh0;
  logic [4:0]  sh1;
  logic [12:0] emitted1;
  logic        done;
  logic [2:0]  rem;
  logic [6:0]  lob;
  logic [7:0]  rem_mask;
  logic [7:0]  flush_byte;
  logic [1:0]  total;

  // Slice width and stream limit, both saturated.
  assign n    = (element_bits > 5'd16) ? 5'd16 : element_bits;
  assign lim  = (max_bytes > 13'(ftbp_pkg::MAX_OUT_BYTES)) ?
                13'(ftbp_pkg::MAX_OUT_BYTES) : max_bytes;
  assign mask = 16'((17'd1 << n) - 17'd1);

  // Append the new slice below the pending bits.
  assign acc  = ({16'b0, state.lo_bits} << n) | {7'b0, element & mask};
  assign cnt  = {2'b0, state.lo_cnt} + n;
  assign full = cnt[4:3];

  // Number of full bytes that still fit under the limit.
  assign at_lim = (state.emitted >= lim);
  assign room   = lim - state.emitted;
  always_comb begin
    if (at_lim) begin
      emit = 2'd0;
    end else if (room < {11'b0, full}) begin
      emit = room[1:0];
    end else begin
      emit = full;
    end
  end

  assign sh0      = cnt - 5'd8;
  assign sh1      = cnt - 5'd16;
  assign emitted1 = state.emitted + {11'b0, emit};
  assign done     = (emitted1 >= lim);

  // Bits left pending after the full bytes; all dropped once the limit is hit.
  assign rem        = done ? 3'd0 : cnt[2:0];
  assign rem_mask   = (8'd1 << rem) - 8'd1;
  assign lob        = acc[6:0] & rem_mask[6:0];
  assign flush_byte = {1'b0, lob} << (4'd8 - {1'b0, rem});

  // Assemble the result bytes and the state for the next item.
  always_comb begin
    res.bytes    = '0;
    res.lasts    = '0;
    res.bytes[0] = 8'(acc >> sh0);
    res.bytes[1] = 8'(acc >> sh1);
    res.lasts[0] = ((state.emitted + 13'd1) == lim);
    res.lasts[1] = ((state.emitted + 13'd2) == lim);
    total        = emit;
    res.state.lo_bits = lob;
    res.state.lo_cnt  = rem;
    res.state.emitted = emitted1;
    if (last_element) begin
      if (rem != 3'd0) begin
        res.bytes[emit] = flush_byte;
        res.lasts[emit] = 1'b0;
        total           = emit + 2'd1;
      end
      if (total != 2'd0) begin
        res.lasts[total - 2'd1] = 1'b1;
      end
      res.state = '0;
    end
    res.count = total;
  end

endmodule

// ----- sv/field_to_byte_packer.sv -----
// An accepted item waits in the input register and then loads into the output queue;
// it stays in the input register while the queue still holds bytes that are not leaving.
// Throughput: one item per cycle when it yields at most one byte and the receiver takes
// every byte; otherwise the next item waits until the bytes of the one before drain.
// Reset (rst_n low, synchronous) empties the input stage, the output queue and
// the packer state, and sets element_bits to 15 and max_bytes to 4096.
module field_to_byte_packer (
  input  logic              clk,
  input  logic              rst_n,
  ftbp_in_if.sink           in_ch,
  ftbp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data
);

  logic [4:0]  element_bits_r;
  logic [12:0] max_bytes_r;

  logic        in_v_r;
  logic [15:0] in_elem_r;
  logic        in_last_r;

  ftbp_pkg::pack_state_t state_r;
  ftbp_pkg::pack_res_t   core_res;

  logic [7:0] buf_byte_r [ftbp_pkg::RES_MAX];
  logic       buf_last_r [ftbp_pkg::RES_MAX];
  logic [1:0] buf_cnt_r;

  logic pop;
  logic load;
  logic take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_bits_r <= 5'd15;
      max_bytes_r    <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftbp_pkg::CFG_ELEMENT_BITS: element_bits_r <= cfg_data[4:0];
        ftbp_pkg::CFG_MAX_BYTES:    max_bytes_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes: an item moves into the queue when the queue is empty or frees now.
  assign pop   = out_ch.valid && out_ch.ready;
  assign load  = in_v_r && ((buf_cnt_r == 2'd0) || ((buf_cnt_r == 2'd1) && pop));
  assign take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_v_r || load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (take) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_elem_r <= in_ch.element;
      in_last_r <= in_ch.last_element;
    end
  end

  ftbp_core u_core (
    .element_bits (element_bits_r),
    .max_bytes    (max_bytes_r),
    .element      (in_elem_r),
    .last_element (in_last_r),
    .state        (state_r),
    .res          (core_res)
  );

  // Packer state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (load) begin
      state_r <= core_res.state;
    end
  end

  // Output queue: loaded with all bytes of an item, drained from entry zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= 2'd0;
    end else if (load) begin
      buf_cnt_r <= core_res.count;
    end else if (pop) begin
      buf_cnt_r <= buf_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < ftbp_pkg::RES_MAX; i++) begin
        buf_byte_r[i] <= core_res.bytes[i];
        buf_last_r[i] <= core_res.lasts[i];
      end
    end else if (pop) begin
      for (int i = 0; i < ftbp_pkg::RES_MAX - 1; i++) begin
        buf_byte_r[i] <= buf_byte_r[i+1];
        buf_last_r[i] <= buf_last_r[i+1];
      end
    end
  end

  assign out_ch.valid       = (buf_cnt_r != 2'd0);
  assign out_ch.packed_byte = buf_byte_r[0];
  assign out_ch.last_byte   = buf_last_r[0];

  // A last item always leaves the packer empty.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_last_r |=> (state_r.lo_cnt == 3'd0) && (state_r.emitted == 13'd0))
    else $error("packer state not cleared after last item");

  // The byte count never passes the hard ceiling.
  a_emitted_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.emitted <= 13'(ftbp_pkg::MAX_OUT_BYTES))
    else $error("emitted byte count above ceiling");

  // The queue holds exactly the bytes of the item just loaded.
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> buf_cnt_r == $past(core_res.count))
    else $error("output queue count mismatch after load");

  // An item is never loaded over bytes still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && (buf_cnt_r != 2'd0) |-> pop && (buf_cnt_r == 2'd1))
    else $error("output queue overwritten");

endmodule

// ----- verif/tb.sv -----
module tb;

  // One element as it goes into the packer, and one byte as it comes out.
  typedef struct packed {
    logic [15:0] element;
    logic        last_element;
  } element_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } byte_item_t;

  localparam int RANDOM_TARGET = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int MAX_GAP       = 7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;

  ftbp_in_if  in_ch ();
  ftbp_out_if out_ch ();

  field_to_byte_packer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Elements waiting to be offered, and bytes the packer still owes.
  element_item_t pending_elements[$];
  byte_item_t    expected_bytes[$];

  // Shadow copies of the registers and of the packer state.
  logic [4:0]  width_reg    = 5'd15;
  logic [12:0] limit_reg    = 13'd4096;
  logic [6:0]  held_bits    = '0;
  logic [2:0]  held_count   = '0;
  logic [12:0] stream_bytes = '0;

  // Handshake bookkeeping shared by the processes.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  logic no_gaps  = 1'b0;
  int   elements_queued   = 0;
  int   elements_accepted = 0;
  int   bytes_checked     = 0;
  int   fail_count        = 0;
  int   hold_req          = 0;
  int   hold_ack          = 0;
  int   hold_left         = 0;
  int   send_gap          = 0;
  int   stall_left        = 0;
  element_item_t next_element;

  // Stimulus control variables.
  int          random_elements = 0;
  int          settings_used   = 0;
  int          phase_count     = 0;
  int          phase_len       = 0;
  int          stream_len      = 0;
  int          stream_pos      = 0;
  logic [4:0]  new_width;
  logic [12:0] new_limit;
  logic [15:0] rand_element;
  logic        rand_last;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Appends the slice to the shadow bit stream and records the bytes it completes or flushes.
  task automatic pack_element(input logic [15:0] elem, input logic last);
    int unsigned width;
    int unsigned limit;
    int unsigned acc;
    int unsigned cnt;
    int unsigned emitted;
    int          n_out;
    byte_item_t  fresh[ftbp_pkg::RES_MAX];
    width   = (width_reg > ftbp_pkg::ELEM_W) ? ftbp_pkg::ELEM_W : width_reg;
    limit   = (limit_reg > ftbp_pkg::MAX_OUT_BYTES) ? ftbp_pkg::MAX_OUT_BYTES : limit_reg;
    acc     = (int'(held_bits) << width) | (elem & ((1 << width) - 1));
    cnt     = held_count + width;
    emitted = stream_bytes;
    n_out   = 0;
    while (cnt >= 8 && emitted < limit) begin
      cnt = cnt - 8;
      emitted++;
      fresh[n_out].packed_byte = 8'((acc >> cnt) & 8'hFF);
      fresh[n_out].last_byte   = (emitted == limit);
      n_out++;
    end
    // Once the limit is hit, everything else in the stream is dropped.
    if (emitted >= limit)
      cnt = 0;
    acc = acc & ((1 << cnt) - 1);
    if (last) begin
      if (cnt > 0 && emitted < limit) begin
        fresh[n_out].packed_byte = 8'((acc << (8 - cnt)) & 8'hFF);
        fresh[n_out].last_byte   = 1'b0;
        n_out++;
      end
      if (n_out > 0)
        fresh[n_out-1].last_byte = 1'b1;
      acc     = 0;
      cnt     = 0;
      emitted = 0;
    end
    held_bits    = acc[6:0];
    held_count   = cnt[2:0];
    stream_bytes = emitted[12:0];
    for (int i = 0; i < n_out; i++)
      expected_bytes.push_back(fresh[i]);
  endtask

  // Writes one register and updates the shadow copy; only called while the packer is idle.
  task automatic set_register(input logic idx, input logic [12:0] value);
    if (idx == ftbp_pkg::CFG_ELEMENT_BITS)
      width_reg = value[4:0];
    else
      limit_reg = value;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [4:0] width, input logic [12:0] limit);
    set_register(ftbp_pkg::CFG_ELEMENT_BITS, {8'd0, width});
    set_register(ftbp_pkg::CFG_MAX_BYTES, limit);
    settings_used++;
  endtask

  task automatic queue_element(input logic [15:0] elem, input logic last);
    pending_elements.push_back('{elem, last});
    elements_queued++;
  endtask

  // Waits until every queued element is taken and every owed byte has come out, then settles.
  task automatic wait_until_idle();
    while (elements_accepted != elements_queued || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: offers the queued elements with a random gap after each accepted one, unless gaps are off.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_fire)
        send_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_elements.size() > 0) begin
        next_element = pending_elements.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.element      <= next_element.element;
        in_ch.last_element <= next_element.last_element;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stall after each byte, plus long holds on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (out_fire)
        stall_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted element and checks every accepted byte.
  always @(posedge clk) begin
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      elements_accepted++;
      pack_element(in_ch.element, in_ch.last_element);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("packed_byte: expected none, got %h", out_ch.packed_byte);
        fail_count++;
      end else begin
        if (out_ch.packed_byte !== expected_bytes[0].packed_byte) begin
          $error("packed_byte: expected %h, got %h",
                 expected_bytes[0].packed_byte, out_ch.packed_byte);
          fail_count++;
        end
        if (out_ch.last_byte !== expected_bytes[0].last_byte) begin
          $error("last_byte: expected %b, got %b",
                 expected_bytes[0].last_byte, out_ch.last_byte);
          fail_count++;
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = ftbp_pkg::CFG_ELEMENT_BITS;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.element      = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extreme element values across byte boundaries.
    queue_element(16'hFFFF, 1'b0);
    queue_element(16'h0000, 1'b0);
    queue_element(16'h8001, 1'b0);
    queue_element(16'h7FFE, 1'b1);
    wait_until_idle();

    // Full 16-bit slices.
    configure(5'd16, 13'd4096);
    queue_element(16'hFFFF, 1'b0);
    queue_element(16'h0000, 1'b1);
    wait_until_idle();

    // Zero width: nothing is taken, so the last element yields no byte.
    configure(5'd0, 13'd4096);
    queue_element(16'h1234, 1'b0);
    queue_element(16'hFFFF, 1'b1);
    wait_until_idle();

    // Width setting above 16 saturates.
    configure(5'd31, 13'd4096);
    queue_element(16'hA5C3, 1'b0);
    queue_element(16'h5A3C, 1'b1);
    wait_until_idle();

    // Limit reached after two bytes; the rest of the stream is dropped.
    configure(5'd3, 13'd2);
    for (int i = 0; i < 6; i++)
      queue_element(16'hFFF0 | 16'(i), 1'b0);
    queue_element(16'h0005, 1'b1);
    wait_until_idle();

    // Zero limit: no byte at all.
    configure(5'd8, 13'd0);
    queue_element(16'h00FF, 1'b0);
    queue_element(16'h0012, 1'b1);
    wait_until_idle();

    // Limit above the ceiling saturates; an exact byte carries the last mark.
    configure(5'd8, 13'd8191);
    queue_element(16'hEEC3, 1'b1);
    wait_until_idle();

    // Limit lowered below the bytes already sent in the open stream.
    configure(5'd12, 13'd4096);
    queue_element(16'h0ABC, 1'b0);
    queue_element(16'h0DEF, 1'b0);
    wait_until_idle();
    set_register(ftbp_pkg::CFG_MAX_BYTES, 13'd2);
    limit_reg = 13'd2;
    queue_element(16'h0123, 1'b1);
    wait_until_idle();

    // Random phases of mostly well-formed streams; open streams carry across settings.
    while (random_elements < RANDOM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       new_width = 5'd1;
        1:       new_width = 5'd16;
        2:       new_width = 5'd0;
        3:       new_width = 5'($urandom_range(17, 31));
        default: new_width = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 9))
        0:       new_limit = 13'd0;
        1:       new_limit = 13'($urandom_range(1, 6));
        2:       new_limit = 13'd8191;
        3:       new_limit = 13'($urandom_range(4097, 8190));
        4:       new_limit = 13'($urandom_range(7, 60));
        default: new_limit = 13'd4096;
      endcase
      configure(new_width, new_limit);
      no_gaps = ($urandom_range(0, 3) == 0);
      // Long receiver hold while the sender keeps offering.
      if (phase_count % 6 == 2)
        hold_req++;
      phase_len = $urandom_range(20, 40);
      for (int i = 0; i < phase_len; i++) begin
        if (stream_pos == 0)
          stream_len = $urandom_range(1, 12);
        stream_pos++;
        case ($urandom_range(0, 7))
          0:       rand_element = 16'hFFFF;
          1:       rand_element = 16'h0000;
          default: rand_element = 16'($urandom_range(0, 65535));
        endcase
        rand_last = (stream_pos >= stream_len);
        // Occasionally break the stream: early end or a missing end mark.
        if ($urandom_range(0, 11) == 0)
          rand_last = ~rand_last;
        if (rand_last)
          stream_pos = 0;
        queue_element(rand_element, rand_last);
        random_elements++;
      end
      phase_count++;
      wait_until_idle();
    end

    $display("Packed %0d elements into %0d checked bytes.", elements_accepted, bytes_checked);
    $display("Used %0d register settings over %0d random phases, %0d long output holds.",
             settings_used, phase_count, hold_req);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
